// ===== rtl/ebm_pkg.sv =====
`timescale 1ns / 1ps
package ebm_pkg;

  localparam int EMS_SETS_DEF    = 4;
  localparam int EMS_WINDOWS_DEF = 4;

  // Set and window indexes are carried at the widest legal size.
  localparam int IDX_W = 2;

  typedef enum logic [1:0] {
    FN_MEM_RD = 2'd0,
    FN_MEM_WR = 2'd1,
    FN_IO_RD  = 2'd2,
    FN_IO_WR  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    TGT_NONE  = 3'd0,
    TGT_RAM   = 3'd1,
    TGT_VRAM  = 3'd2,
    TGT_IPL   = 3'd3,
    TGT_KANJI = 3'd4,
    TGT_EMS   = 3'd5
  } target_t;

  localparam logic [23:0] RAM_END      = 24'h0a0000;
  localparam logic [8:0]  VRAM_PAGE    = 9'h017;   // 0x0B8000 >> 15
  localparam logic [7:0]  EMS_SEG      = 8'h0d;
  localparam logic [7:0]  KANJI_SEG    = 8'h0e;
  localparam logic [7:0]  IPL_SEG_LO   = 8'h0f;
  localparam logic [7:0]  IPL_SEG_HI   = 8'hff;
  localparam logic [7:0]  UNMAPPED_RD  = 8'hff;

  // Page register port, low 14 bits, one per set.
  localparam logic [13:0] PAGE_PORT [4] = '{14'h208, 14'h218, 14'h258, 14'h268};

  typedef struct packed {
    target_t     target;
    logic [22:0] offset;
    logic        write_enable;
    logic [7:0]  read_data;
  } result_t;

  typedef struct packed {
    logic             page_we;
    logic [IDX_W-1:0] page_set;
    logic [IDX_W-1:0] page_win;
    logic [7:0]       page_data;
    logic             kanji_we;
    logic [4:0]       kanji_data;
  } reg_wr_t;

endpackage

// ===== rtl/ebm_regs.sv =====
`timescale 1ns / 1ps
module ebm_regs
  import ebm_pkg::*;
#(
  parameter int EMS_SETS    = EMS_SETS_DEF,
  parameter int EMS_WINDOWS = EMS_WINDOWS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  reg_wr_t                                 wr,
  output logic [EMS_SETS-1:0][EMS_WINDOWS-1:0][7:0] pages,
  output logic [4:0]                              kanji
);

  always_ff @(posedge clk) begin
    if (rst) begin
      pages <= '0;
      kanji <= '0;
    end else begin
      for (int s = 0; s < EMS_SETS; s++) begin
        for (int w = 0; w < EMS_WINDOWS; w++) begin
          if (wr.page_we && wr.page_set == IDX_W'(s) && wr.page_win == IDX_W'(w)) begin
            pages[s][w] <= wr.page_data;
          end
        end
      end
      if (wr.kanji_we) begin
        kanji <= wr.kanji_data;
      end
    end
  end

endmodule

// ===== rtl/ebm_decode.sv =====
`timescale 1ns / 1ps
module ebm_decode
  import ebm_pkg::*;
#(
  parameter int EMS_SETS    = EMS_SETS_DEF,
  parameter int EMS_WINDOWS = EMS_WINDOWS_DEF
) (
  input  logic [1:0]                              func,
  input  logic [23:0]                             addr,
  input  logic [7:0]                              data,
  input  logic                                    active,
  input  logic [EMS_SETS-1:0][EMS_WINDOWS-1:0][7:0] pages,
  input  logic [4:0]                              kanji,
  output result_t                                 res,
  output reg_wr_t                                 wr
);

  target_t          mem_tgt;
  logic [22:0]      mem_ofs;
  logic             mem_writable;
  logic [7:0]       ems_reg;
  logic             ems_hit;
  logic [IDX_W-1:0] ems_set;
  logic [IDX_W-1:0] win;
  logic             io_hit;
  logic [IDX_W-1:0] io_set;
  logic [7:0]       io_reg;

  assign win = addr[15:14];

  // Lowest enabled set wins: scan downward so it is assigned last.
  always_comb begin
    ems_hit = 1'b0;
    ems_set = '0;
    ems_reg = '0;
    for (int s = EMS_SETS - 1; s >= 0; s--) begin
      for (int w = 0; w < EMS_WINDOWS; w++) begin
        if (win == IDX_W'(w) && pages[s][w][7]) begin
          ems_hit = 1'b1;
          ems_set = IDX_W'(s);
          ems_reg = pages[s][w];
        end
      end
    end
  end

  always_comb begin
    mem_tgt      = TGT_NONE;
    mem_ofs      = '0;
    mem_writable = 1'b0;
    if (addr < RAM_END) begin
      mem_tgt      = TGT_RAM;
      mem_ofs      = addr[22:0];
      mem_writable = 1'b1;
    end else if (addr[23:15] == VRAM_PAGE) begin
      mem_tgt      = TGT_VRAM;
      mem_ofs      = {8'd0, addr[14:0]};
      mem_writable = 1'b1;
    end else if (addr[23:16] == EMS_SEG) begin
      if (ems_hit) begin
        mem_tgt      = TGT_EMS;
        mem_ofs      = {ems_set, ems_reg[6:0], addr[13:0]};
        mem_writable = 1'b1;
      end
    end else if (addr[23:16] == KANJI_SEG) begin
      if (kanji[4]) begin
        mem_tgt = TGT_KANJI;
        mem_ofs = {3'd0, kanji[3:0], addr[15:0]};
      end
    end else if (addr[23:16] inside {IPL_SEG_LO, IPL_SEG_HI}) begin
      mem_tgt = TGT_IPL;
      mem_ofs = {7'd0, addr[15:0]};
    end
  end

  always_comb begin
    io_hit = 1'b0;
    io_set = '0;
    io_reg = UNMAPPED_RD;
    for (int s = 0; s < EMS_SETS; s++) begin
      for (int w = 0; w < EMS_WINDOWS; w++) begin
        if (addr[13:0] == PAGE_PORT[s] && win == IDX_W'(w)) begin
          io_hit = 1'b1;
          io_set = IDX_W'(s);
          io_reg = pages[s][w];
        end
      end
    end
  end

  always_comb begin
    res = '{target: TGT_NONE, offset: '0, write_enable: 1'b0, read_data: '0};
    wr  = '{page_we: 1'b0, page_set: io_set, page_win: win, page_data: data,
            kanji_we: 1'b0, kanji_data: {data[7], data[3:0]}};
    case (func)
      FN_MEM_RD: begin
        res.target = mem_tgt;
        res.offset = mem_ofs;
        if (mem_tgt == TGT_NONE) begin
          res.read_data = UNMAPPED_RD;
        end
      end
      FN_MEM_WR: begin
        if (addr[23:16] == KANJI_SEG) begin
          wr.kanji_we = active;
        end else if (mem_writable) begin
          res.target       = mem_tgt;
          res.offset       = mem_ofs;
          res.write_enable = 1'b1;
        end
      end
      FN_IO_RD: begin
        res.read_data = io_reg;
      end
      FN_IO_WR: begin
        wr.page_we = active && io_hit;
      end
      default: begin
        res.target = TGT_NONE;
      end
    endcase
  end

endmodule

// ===== rtl/ems_bank_memory_mapper.sv =====
`timescale 1ns / 1ps
// Input register, one decode pass, result register; a request's result shows from the latter.
// Throughput: one request per cycle while out_stall does not hold the output.
// Page and kanji bank register writes land as the request moves to the result register,
// so the following request sees them.
// Reset (rst, synchronous): page registers and kanji bank cleared, both stages empty.
module ems_bank_memory_mapper
  import ebm_pkg::*;
#(
  parameter int EMS_SETS    = EMS_SETS_DEF,
  parameter int EMS_WINDOWS = EMS_WINDOWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [23:0] addr,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  target,
  output logic [22:0] offset,
  output logic        write_enable,
  output logic [7:0]  read_data
);

  logic        req_valid;
  logic [1:0]  req_func;
  logic [23:0] req_addr;
  logic [7:0]  req_data;
  logic        out_adv;
  logic        fire;
  result_t     res;
  reg_wr_t     wr;
  logic [EMS_SETS-1:0][EMS_WINDOWS-1:0][7:0] pages;
  logic [4:0]  kanji;

  assign out_adv  = !out_valid || !out_stall;
  assign in_stall = req_valid && !out_adv;
  assign fire     = req_valid && out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_func <= func;
      req_addr <= addr;
      req_data <= data;
    end
  end

  ebm_decode #(
    .EMS_SETS    (EMS_SETS),
    .EMS_WINDOWS (EMS_WINDOWS)
  ) u_decode (
    .func   (req_func),
    .addr   (req_addr),
    .data   (req_data),
    .active (fire),
    .pages  (pages),
    .kanji  (kanji),
    .res    (res),
    .wr     (wr)
  );

  ebm_regs #(
    .EMS_SETS    (EMS_SETS),
    .EMS_WINDOWS (EMS_WINDOWS)
  ) u_regs (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .pages (pages),
    .kanji (kanji)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      target       <= res.target;
      offset       <= res.offset;
      write_enable <= res.write_enable;
      read_data    <= res.read_data;
    end
  end

  a_we_target : assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |->
      (target == TGT_RAM || target == TGT_VRAM || target == TGT_EMS))
    else $error("write enable on a non-writable target");

  a_none_offset : assert property (@(posedge clk) disable iff (rst)
    out_valid && target == TGT_NONE |-> offset == '0)
    else $error("nonzero offset with no target");

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> req_valid && out_valid)
    else $error("input stalled while a stage is free");

  a_reg_write_fire : assert property (@(posedge clk) disable iff (rst)
    wr.page_we || wr.kanji_we |-> fire)
    else $error("register write without a request moving");

endmodule
